FILE: hdl/cffp_pkg.sv
package cffp_pkg;

    // Tag codes carried on field_kind.
    localparam logic [2:0] KIND_TOTAL  = 3'd0;
    localparam logic [2:0] KIND_TYPE   = 3'd1;
    localparam logic [2:0] KIND_ID     = 3'd2;
    localparam logic [2:0] KIND_COUNT  = 3'd3;
    localparam logic [2:0] KIND_LENGTH = 3'd4;
    localparam logic [2:0] KIND_PSEUDO = 3'd5;
    localparam logic [2:0] KIND_TUBE   = 3'd6;
    localparam logic [2:0] KIND_TEXT   = 3'd7;

    // A layout entry of this value means the frame has no further segment.
    localparam logic [2:0] SEG_END = 3'd0;

    // Message type codes carried on msg_type.
    localparam logic [2:0] MSG_NONE = 3'd0;
    localparam logic [2:0] MSG_HELO = 3'd1;
    localparam logic [2:0] MSG_OKOK = 3'd2;
    localparam logic [2:0] MSG_BYEE = 3'd3;
    localparam logic [2:0] MSG_LIST = 3'd4;
    localparam logic [2:0] MSG_SHUT = 3'd5;
    localparam logic [2:0] MSG_BCST = 3'd6;
    localparam logic [2:0] MSG_PRVT = 3'd7;

    localparam logic [31:0] WORD_HELO = "HELO";
    localparam logic [31:0] WORD_OKOK = "OKOK";
    localparam logic [31:0] WORD_BYEE = "BYEE";
    localparam logic [31:0] WORD_LIST = "LIST";
    localparam logic [31:0] WORD_SHUT = "SHUT";
    localparam logic [31:0] WORD_BCST = "BCST";
    localparam logic [31:0] WORD_PRVT = "PRVT";

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Fixed-size fields and length prefixes are four bytes long.
    localparam int unsigned FIXED_BYTES = 4;
    localparam int unsigned CNT_W       = 14;

    // Segment layout per direction and message type: up to three segments.
    localparam logic [2:0] LAYOUT [2][8][3] = '{
        '{
            '{SEG_END,     SEG_END,     SEG_END},
            '{KIND_PSEUDO, KIND_TUBE,   SEG_END},
            '{SEG_END,     SEG_END,     SEG_END},
            '{KIND_ID,     SEG_END,     SEG_END},
            '{KIND_ID,     SEG_END,     SEG_END},
            '{KIND_ID,     SEG_END,     SEG_END},
            '{KIND_ID,     KIND_TEXT,   SEG_END},
            '{KIND_ID,     KIND_PSEUDO, KIND_TEXT}
        },
        '{
            '{SEG_END,     SEG_END,     SEG_END},
            '{SEG_END,     SEG_END,     SEG_END},
            '{KIND_ID,     SEG_END,     SEG_END},
            '{KIND_ID,     SEG_END,     SEG_END},
            '{KIND_COUNT,  KIND_PSEUDO, SEG_END},
            '{KIND_PSEUDO, SEG_END,     SEG_END},
            '{KIND_PSEUDO, KIND_TEXT,   SEG_END},
            '{KIND_PSEUDO, KIND_TEXT,   SEG_END}
        }
    };

    function automatic logic [2:0] layout_seg(input logic       dir,
                                              input logic [2:0] code,
                                              input logic [1:0] idx);
        logic [2:0] seg;
        seg = SEG_END;
        if (idx != 2'd3)
        begin
            seg = LAYOUT[dir][code][idx];
        end
        return seg;
    endfunction

    function automatic logic [2:0] decode_type(input logic [31:0] w);
        logic [2:0] code;
        code = MSG_NONE;
        if (w == WORD_HELO)
        begin
            code = MSG_HELO;
        end
        else if (w == WORD_OKOK)
        begin
            code = MSG_OKOK;
        end
        else if (w == WORD_BYEE)
        begin
            code = MSG_BYEE;
        end
        else if (w == WORD_LIST)
        begin
            code = MSG_LIST;
        end
        else if (w == WORD_SHUT)
        begin
            code = MSG_SHUT;
        end
        else if (w == WORD_BCST)
        begin
            code = MSG_BCST;
        end
        else if (w == WORD_PRVT)
        begin
            code = MSG_PRVT;
        end
        return code;
    endfunction

    typedef enum logic [2:0] {
        MODE_TOTAL = 3'b001,
        MODE_TYPE  = 3'b010,
        MODE_FIELD = 3'b100
    } mode_t;

endpackage

FILE: hdl/chat_frame_field_parser_top.sv
// Chat frame field parser.
// Input channel: in_valid/in_stall carry one raw stream byte (in_byte) per
// transfer. Output channel: out_valid/out_stall carry one tagged byte per
// input byte: the byte itself, its field kind, the message type, and flags
// for end of field, end of frame and a type unknown or without a layout for the direction.
// The direction register (cfg_we/cfg_wdata) selects client-to-server (0) or
// server-to-client (1) layouts; it is sampled on the last byte of the type.
// A byte taken in is held in the input register, parsed into the result
// register and transferred out from there. Throughput is one byte per
// cycle while the output is not stalled, set by the single parse step
// between the input register and the result register.
// When the receiver stalls, the result register holds its contents and the
// input register still takes one more byte; in_stall rises only when both
// registers are full and the output is stalled.
// Reset empties both registers, clears the parser state (next byte is the
// first byte of a total length) and sets direction to client-to-server.
module chat_frame_field_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic [2:0] field_kind,
    output logic [2:0] msg_type,
    output logic       field_last,
    output logic       frame_done,
    output logic       type_error
);

    localparam int unsigned CW = cffp_pkg::CNT_W;

    logic                direction_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                step;

    cffp_pkg::mode_t     mode_reg, mode_next;
    logic                dir_reg, dir_next;
    logic [1:0]          seg_reg, seg_next;
    logic                body_reg, body_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       accum_reg, accum_next;
    logic                stopped_reg, stopped_next;
    logic [23:0]         shift_reg, shift_next;
    logic [2:0]          code_reg, code_next;

    logic [7:0]          data_reg;
    logic [2:0]          kind_reg, kind_next;
    logic [2:0]          mt_reg, mt_next;
    logic                last_reg, last_next;
    logic                done_reg, done_next;
    logic                err_reg, err_next;

    logic [CW-1:0]       cnt1;
    logic                cnt_full;
    logic [2:0]          seg;
    logic [2:0]          new_code;
    logic                is_digit;
    logic [CW-1:0]       accum_dig;
    logic                do_open;
    logic                open_dir;
    logic [1:0]          open_idx;
    logic [2:0]          open_code;
    logic                open_end;
    logic                do_end;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    assign cnt1     = count_reg + CW'(1);
    assign cnt_full = cnt1 >= CW'(cffp_pkg::FIXED_BYTES);
    assign seg      = (seg_reg != 2'd0)
                      ? cffp_pkg::layout_seg(dir_reg, code_reg, seg_reg - 2'd1)
                      : cffp_pkg::SEG_END;
    assign new_code = cffp_pkg::decode_type({shift_reg, in_byte_reg});
    assign is_digit = (in_byte_reg >= cffp_pkg::ASCII_ZERO)
                      && (in_byte_reg <= cffp_pkg::ASCII_NINE);
    // accum * 10 + digit, built from two shifts.
    assign accum_dig = {accum_reg[CW-4:0], 3'b000} + {accum_reg[CW-2:0], 1'b0}
                       + {{(CW-4){1'b0}}, in_byte_reg[3:0]};

    always_comb
    begin
        mode_next    = mode_reg;
        dir_next     = dir_reg;
        seg_next     = seg_reg;
        body_next    = body_reg;
        count_next   = count_reg;
        accum_next   = accum_reg;
        stopped_next = stopped_reg;
        shift_next   = shift_reg;
        code_next    = code_reg;
        kind_next    = cffp_pkg::KIND_TOTAL;
        mt_next      = code_reg;
        last_next    = 1'b0;
        done_next    = 1'b0;
        err_next     = 1'b0;
        do_open      = 1'b0;
        do_end       = 1'b0;
        open_dir     = dir_reg;
        open_idx     = seg_reg;
        open_code    = code_reg;

        unique case (mode_reg)
            cffp_pkg::MODE_TOTAL:
            begin
                kind_next = cffp_pkg::KIND_TOTAL;
                if (cnt_full)
                begin
                    last_next  = 1'b1;
                    mode_next  = cffp_pkg::MODE_TYPE;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt1;
                end
            end
            cffp_pkg::MODE_TYPE:
            begin
                kind_next  = cffp_pkg::KIND_TYPE;
                shift_next = {shift_reg[15:0], in_byte_reg};
                count_next = cnt1;
                if (cnt_full)
                begin
                    last_next = 1'b1;
                    if (new_code != cffp_pkg::MSG_NONE
                        && cffp_pkg::layout_seg(direction_reg, new_code, 2'd0)
                           != cffp_pkg::SEG_END)
                    begin
                        code_next = new_code;
                        mt_next   = new_code;
                        do_open   = 1'b1;
                        open_dir  = direction_reg;
                        open_idx  = 2'd0;
                        open_code = new_code;
                    end
                    else
                    begin
                        err_next  = 1'b1;
                        done_next = 1'b1;
                        mt_next   = cffp_pkg::MSG_NONE;
                        do_end    = 1'b1;
                    end
                end
            end
            cffp_pkg::MODE_FIELD:
            begin
                if (seg == cffp_pkg::SEG_END)
                begin
                    kind_next = cffp_pkg::KIND_TOTAL;
                    last_next = 1'b1;
                    done_next = 1'b1;
                    do_end    = 1'b1;
                end
                else if (seg == cffp_pkg::KIND_ID || seg == cffp_pkg::KIND_COUNT)
                begin
                    kind_next  = seg;
                    count_next = cnt1;
                    if (cnt_full)
                    begin
                        last_next = 1'b1;
                        do_open   = 1'b1;
                    end
                end
                else if (!body_reg)
                begin
                    kind_next  = cffp_pkg::KIND_LENGTH;
                    count_next = cnt1;
                    if (!stopped_reg && is_digit)
                    begin
                        accum_next = accum_dig;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                    if (cnt_full)
                    begin
                        last_next = 1'b1;
                        if (accum_next == '0)
                        begin
                            do_open = 1'b1;
                        end
                        else
                        begin
                            body_next  = 1'b1;
                            count_next = '0;
                        end
                    end
                end
                else
                begin
                    kind_next  = seg;
                    count_next = cnt1;
                    if (cnt1 >= accum_reg)
                    begin
                        last_next = 1'b1;
                        do_open   = 1'b1;
                    end
                end
            end
            default:
            begin
                kind_next = cffp_pkg::KIND_TOTAL;
                last_next = 1'b1;
                done_next = 1'b1;
                do_end    = 1'b1;
            end
        endcase

        open_end = (open_idx == 2'd3)
                   || (cffp_pkg::layout_seg(open_dir, open_code, open_idx)
                       == cffp_pkg::SEG_END);

        if (do_open && !open_end)
        begin
            mode_next    = cffp_pkg::MODE_FIELD;
            dir_next     = open_dir;
            seg_next     = open_idx + 2'd1;
            body_next    = 1'b0;
            count_next   = '0;
            accum_next   = '0;
            stopped_next = 1'b0;
        end
        if (do_open && open_end)
        begin
            done_next = 1'b1;
        end
        if (do_end || (do_open && open_end))
        begin
            mode_next    = cffp_pkg::MODE_TOTAL;
            count_next   = '0;
            accum_next   = '0;
            stopped_next = 1'b0;
            shift_next   = '0;
            code_next    = cffp_pkg::MSG_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= cffp_pkg::MODE_TOTAL;
            dir_reg       <= 1'b0;
            seg_reg       <= 2'd0;
            body_reg      <= 1'b0;
            count_reg     <= '0;
            accum_reg     <= '0;
            stopped_reg   <= 1'b0;
            shift_reg     <= '0;
            code_reg      <= cffp_pkg::MSG_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_wdata;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                mode_reg    <= mode_next;
                dir_reg     <= dir_next;
                seg_reg     <= seg_next;
                body_reg    <= body_next;
                count_reg   <= count_next;
                accum_reg   <= accum_next;
                stopped_reg <= stopped_next;
                shift_reg   <= shift_next;
                code_reg    <= code_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
        if (step)
        begin
            data_reg <= in_byte_reg;
            kind_reg <= kind_next;
            mt_reg   <= mt_next;
            last_reg <= last_next;
            done_reg <= done_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_reg;
    assign field_kind = kind_reg;
    assign msg_type   = mt_reg;
    assign field_last = last_reg;
    assign frame_done = done_reg;
    assign type_error = err_reg;

endmodule

FILE: hdl/cffp_checker.sv
module cffp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic [2:0] field_kind,
    input logic [2:0] msg_type,
    input logic       field_last,
    input logic       frame_done,
    input logic       type_error
);

    // A stalled result stays put until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte)
                                   && $stable(field_kind) && $stable(frame_done))
        else $error("stalled result changed");

    // The input side only backs up when the output side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // The end of a frame is always the end of a field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> field_last)
        else $error("frame ended inside a field");

    // An unknown type ends the frame on the last type byte with no type code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && type_error |-> frame_done && field_last
                                    && field_kind == cffp_pkg::KIND_TYPE
                                    && msg_type == cffp_pkg::MSG_NONE)
        else $error("type error tagged wrongly");

    // Bytes past the type always carry a known message type.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_kind != cffp_pkg::KIND_TOTAL
                  && field_kind != cffp_pkg::KIND_TYPE
        |-> msg_type != cffp_pkg::MSG_NONE)
        else $error("field byte without a message type");

endmodule

bind chat_frame_field_parser_top cffp_checker u_cffp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .field_kind (field_kind),
    .msg_type   (msg_type),
    .field_last (field_last),
    .frame_done (frame_done),
    .type_error (type_error)
);
